/* rtl/core/psfe_pkg.sv */
// Shared constants, types and helpers for the pyramid shape function evaluator.
`timescale 1ns / 1ps
package psfe_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 18;
  localparam int NODE_W    = 3;
  localparam int NUM_OPS   = 4;
  localparam int OP_W      = 2;

  // Magnitude bound of 1 - zeta and of the divisor
  localparam int MAG_HI = (FRAC_BITS > IN_W - 1) ? FRAC_BITS : IN_W - 1;
  localparam int D_W    = MAG_HI + 2;
  localparam int DM_W   = MAG_HI + 1;
  localparam int DIV_W  = 2 * DM_W;
  localparam int XY_W   = 2 * IN_W;
  localparam int NUM_W  = XY_W - 1 + FRAC_BITS;
  localparam int QS_W   = NUM_W + 1;
  localparam int SUM_W  = QS_W + 2;

  localparam int QDEPTH = 16;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = PTR_W + 1;

  localparam logic [NODE_W-1:0] NODE_FIRST     = NODE_W'(0);
  localparam logic [NODE_W-1:0] NODE_LAST_BASE = NODE_W'(3);
  localparam logic [NODE_W-1:0] NODE_APEX      = NODE_W'(4);

  localparam logic signed [D_W-1:0]   ONE_D   = D_W'(1) <<< FRAC_BITS;
  localparam logic signed [SUM_W-1:0] ONE_S   = SUM_W'(1) <<< FRAC_BITS;
  localparam logic signed [SUM_W-1:0] QTR_S   = ONE_S >>> 2;
  localparam logic signed [SUM_W-1:0] RND_S   = SUM_W'(2);
  localparam logic signed [SUM_W-1:0] OUT_MAX = (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1) <<< (OUT_W - 1));

  // Division ops issued per point: xy/den, y*S/den, x*S/den, xy*S/d^2
  typedef enum logic [OP_W-1:0] {
    OP_XY  = 2'd0,
    OP_Y   = 2'd1,
    OP_X   = 2'd2,
    OP_XYZ = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic                   apex;
    logic                   outside;
  } ctx_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              neg;
    logic [NUM_W-1:0]  num;
    logic [DIV_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              neg;
    logic [NUM_W-1:0]  quo;
    logic              nz;
  } div_res_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = v;
    if (v > OUT_MAX) t = OUT_MAX;
    if (v < OUT_MIN) t = OUT_MIN;
    return t[OUT_W-1:0];
  endfunction

endpackage

/* rtl/core/psfe_front.sv */
// Front end: accepts points, forms products and issues four division ops per point.
`timescale 1ns / 1ps
module psfe_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [psfe_pkg::IN_W-1:0]  xi,
  input  logic signed [psfe_pkg::IN_W-1:0]  eta,
  input  logic signed [psfe_pkg::IN_W-1:0]  zeta,
  input  logic                              q_full,
  output logic                              alloc,
  output psfe_pkg::ctx_t                    ctx,
  output psfe_pkg::div_req_t                req
);

  logic                                busy;
  psfe_pkg::op_t                       op;
  logic signed [psfe_pkg::IN_W-1:0]    x_r;
  logic signed [psfe_pkg::IN_W-1:0]    y_r;
  logic signed [psfe_pkg::XY_W-1:0]    xy;
  logic [psfe_pkg::DIV_W-1:0]          dd;
  logic [psfe_pkg::DM_W-1:0]           den_abs;
  logic                                flip;

  logic                                accept;
  logic signed [psfe_pkg::D_W-1:0]     d_in;
  logic signed [psfe_pkg::D_W-1:0]     den_in;
  logic [psfe_pkg::DM_W-1:0]           d_abs_in;
  logic                                apex_in;
  logic signed [psfe_pkg::NUM_W:0]     nv;
  logic signed [psfe_pkg::NUM_W:0]     nv_adj;
  logic signed [psfe_pkg::NUM_W:0]     nv_mag;

  assign full   = q_full || (busy && (op != psfe_pkg::OP_XYZ));
  assign accept = push && !full;
  assign alloc  = accept;

  assign d_in     = psfe_pkg::ONE_D - psfe_pkg::D_W'(zeta);
  assign apex_in  = (psfe_pkg::D_W'(zeta) == psfe_pkg::ONE_D);
  assign den_in   = apex_in ? psfe_pkg::ONE_D : d_in;
  assign d_abs_in = d_in[psfe_pkg::D_W-1] ? psfe_pkg::DM_W'(-d_in) : psfe_pkg::DM_W'(d_in);

  assign ctx.x       = xi;
  assign ctx.y       = eta;
  assign ctx.z       = zeta;
  assign ctx.apex    = apex_in;
  assign ctx.outside = zeta[psfe_pkg::IN_W-1];

  // Numerator of the current op, sign folded so the divisor is positive
  always_comb begin
    unique case (op)
      psfe_pkg::OP_XY:  nv = (psfe_pkg::NUM_W+1)'(xy);
      psfe_pkg::OP_Y:   nv = (psfe_pkg::NUM_W+1)'(y_r) <<< psfe_pkg::FRAC_BITS;
      psfe_pkg::OP_X:   nv = (psfe_pkg::NUM_W+1)'(x_r) <<< psfe_pkg::FRAC_BITS;
      psfe_pkg::OP_XYZ: nv = (psfe_pkg::NUM_W+1)'(xy) <<< psfe_pkg::FRAC_BITS;
      default:          nv = '0;
    endcase
    nv_adj = (flip && (op != psfe_pkg::OP_XYZ)) ? -nv : nv;
    nv_mag = nv_adj[psfe_pkg::NUM_W] ? -nv_adj : nv_adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      op        <= psfe_pkg::OP_XY;
      req.valid <= 1'b0;
    end else begin
      req.valid <= busy;
      if (accept) begin
        busy <= 1'b1;
        op   <= psfe_pkg::OP_XY;
      end else if (busy) begin
        if (op == psfe_pkg::OP_XYZ) busy <= 1'b0;
        op <= psfe_pkg::op_t'(op + 2'd1);
      end
    end
    if (accept) begin
      x_r     <= xi;
      y_r     <= eta;
      xy      <= xi * eta;
      dd      <= d_abs_in * d_abs_in;
      den_abs <= den_in[psfe_pkg::D_W-1] ? psfe_pkg::DM_W'(-den_in)
                                          : psfe_pkg::DM_W'(den_in);
      flip    <= den_in[psfe_pkg::D_W-1];
    end
    req.op  <= op;
    req.neg <= nv_adj[psfe_pkg::NUM_W];
    req.num <= nv_mag[psfe_pkg::NUM_W-1:0];
    req.den <= (op == psfe_pkg::OP_XYZ) ? dd : psfe_pkg::DIV_W'(den_abs);
  end

endmodule

/* rtl/core/psfe_div.sv */
// Pipelined restoring divider: one quotient bit per stage, a new op every cycle.
`timescale 1ns / 1ps
module psfe_div (
  input  logic                clk,
  input  logic                rst,
  input  psfe_pkg::div_req_t  req,
  output psfe_pkg::div_res_t  res
);

  typedef struct packed {
    logic                         valid;
    psfe_pkg::op_t                op;
    logic                         neg;
    logic [psfe_pkg::NUM_W-1:0]   num;
    logic [psfe_pkg::DIV_W-1:0]   rem;
    logic [psfe_pkg::DIV_W-1:0]   den;
  } stage_t;

  stage_t st [psfe_pkg::NUM_W+1];

  assign st[0].valid = req.valid;
  assign st[0].op    = req.op;
  assign st[0].neg   = req.neg;
  assign st[0].num   = req.num;
  assign st[0].rem   = '0;
  assign st[0].den   = req.den;

  for (genvar i = 0; i < psfe_pkg::NUM_W; i++) begin : g_stage
    logic [psfe_pkg::DIV_W:0] trial;
    logic                     ge;
    assign trial = {st[i].rem, st[i].num[psfe_pkg::NUM_W-1]};
    assign ge    = trial >= {1'b0, st[i].den};
    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].valid <= 1'b0;
      end else begin
        st[i+1].valid <= st[i].valid;
      end
      st[i+1].op  <= st[i].op;
      st[i+1].neg <= st[i].neg;
      st[i+1].den <= st[i].den;
      // Quotient bits shift in where numerator bits leave
      st[i+1].num <= {st[i].num[psfe_pkg::NUM_W-2:0], ge};
      st[i+1].rem <= ge ? psfe_pkg::DIV_W'(trial - {1'b0, st[i].den})
                        : trial[psfe_pkg::DIV_W-1:0];
    end
  end

  assign res.valid = st[psfe_pkg::NUM_W].valid;
  assign res.op    = st[psfe_pkg::NUM_W].op;
  assign res.neg   = st[psfe_pkg::NUM_W].neg;
  assign res.quo   = st[psfe_pkg::NUM_W].num;
  assign res.nz    = |st[psfe_pkg::NUM_W].rem;

endmodule

/* rtl/core/psfe_back.sv */
// Back end: per-point queue of quotients and the five-beat result formatter.
`timescale 1ns / 1ps
module psfe_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                alloc,
  input  psfe_pkg::ctx_t                      ctx,
  output logic                                q_full,
  input  psfe_pkg::div_res_t                  res,
  output logic                                empty,
  input  logic                                pop,
  output logic [psfe_pkg::NODE_W-1:0]         node,
  output logic signed [psfe_pkg::OUT_W-1:0]   shape_value,
  output logic signed [psfe_pkg::OUT_W-1:0]   deriv_xi,
  output logic signed [psfe_pkg::OUT_W-1:0]   deriv_eta,
  output logic signed [psfe_pkg::OUT_W-1:0]   deriv_zeta,
  output logic                                outside,
  output logic                                last
);

  psfe_pkg::ctx_t                   ctx_mem [psfe_pkg::QDEPTH];
  logic signed [psfe_pkg::QS_W-1:0] fpos_mem [psfe_pkg::QDEPTH][psfe_pkg::NUM_OPS];
  logic signed [psfe_pkg::QS_W-1:0] fneg_mem [psfe_pkg::QDEPTH][psfe_pkg::NUM_OPS];

  logic [psfe_pkg::PTR_W-1:0]  alloc_ptr;
  logic [psfe_pkg::PTR_W-1:0]  fill_ptr;
  logic [psfe_pkg::PTR_W-1:0]  rd_ptr;
  logic [psfe_pkg::CNT_W-1:0]  n_alloc;
  logic [psfe_pkg::CNT_W-1:0]  n_ready;
  logic [psfe_pkg::NODE_W-1:0] node_cnt;
  logic                        ovalid;

  logic                             fill_done;
  logic                             have;
  logic                             ld;
  logic                             free;
  logic signed [psfe_pkg::QS_W-1:0] q_s;
  logic signed [psfe_pkg::QS_W-1:0] f_pos;
  logic signed [psfe_pkg::QS_W-1:0] f_neg;

  psfe_pkg::ctx_t                   hc;
  logic                             sx_pos;
  logic                             sy_pos;
  logic                             sxy_pos;
  logic signed [psfe_pkg::SUM_W-1:0] xs;
  logic signed [psfe_pkg::SUM_W-1:0] ys;
  logic signed [psfe_pkg::SUM_W-1:0] zs;
  logic signed [psfe_pkg::SUM_W-1:0] fa;
  logic signed [psfe_pkg::SUM_W-1:0] fb;
  logic signed [psfe_pkg::SUM_W-1:0] fc;
  logic signed [psfe_pkg::SUM_W-1:0] fd;
  logic signed [psfe_pkg::SUM_W-1:0] t_val;
  logic signed [psfe_pkg::SUM_W-1:0] t_b;
  logic signed [psfe_pkg::SUM_W-1:0] t_c;
  logic signed [psfe_pkg::SUM_W-1:0] t_d;
  logic signed [psfe_pkg::SUM_W-1:0] v_val;
  logic signed [psfe_pkg::SUM_W-1:0] v_xi;
  logic signed [psfe_pkg::SUM_W-1:0] v_eta;
  logic signed [psfe_pkg::SUM_W-1:0] v_zeta;

  assign q_full    = (n_alloc == psfe_pkg::CNT_W'(psfe_pkg::QDEPTH));
  assign fill_done = res.valid && (res.op == psfe_pkg::OP_XYZ);
  assign have      = (n_ready != '0);
  assign ld        = have && (!ovalid || pop);
  assign free      = ld && (node_cnt == psfe_pkg::NODE_APEX);
  assign empty     = !ovalid;

  // floor(n/den) and floor(-n/den) from the magnitude quotient
  assign q_s   = psfe_pkg::QS_W'(res.quo);
  assign f_pos = res.neg ? -q_s - psfe_pkg::QS_W'(res.nz) : q_s;
  assign f_neg = -f_pos - psfe_pkg::QS_W'(res.nz);

  always_comb begin
    hc      = ctx_mem[rd_ptr];
    sx_pos  = (node_cnt == 3'd0) || (node_cnt == psfe_pkg::NODE_LAST_BASE);
    sy_pos  = (node_cnt < 3'd2);
    sxy_pos = (sx_pos == sy_pos);
    xs = psfe_pkg::SUM_W'(hc.x);
    ys = psfe_pkg::SUM_W'(hc.y);
    zs = psfe_pkg::SUM_W'(hc.z);
    fa = psfe_pkg::SUM_W'(sxy_pos ? fpos_mem[rd_ptr][psfe_pkg::OP_XY]
                                  : fneg_mem[rd_ptr][psfe_pkg::OP_XY]);
    fb = psfe_pkg::SUM_W'(sxy_pos ? fpos_mem[rd_ptr][psfe_pkg::OP_Y]
                                  : fneg_mem[rd_ptr][psfe_pkg::OP_Y]);
    fc = psfe_pkg::SUM_W'(sxy_pos ? fpos_mem[rd_ptr][psfe_pkg::OP_X]
                                  : fneg_mem[rd_ptr][psfe_pkg::OP_X]);
    fd = psfe_pkg::SUM_W'(sxy_pos ? fpos_mem[rd_ptr][psfe_pkg::OP_XYZ]
                                  : fneg_mem[rd_ptr][psfe_pkg::OP_XYZ]);
    // Round to nearest quarter, ties up
    t_val = psfe_pkg::ONE_S + (sx_pos ? xs : -xs) + (sy_pos ? ys : -ys) - zs
            + fa + psfe_pkg::RND_S;
    t_b   = fb + psfe_pkg::RND_S;
    t_c   = fc + psfe_pkg::RND_S;
    t_d   = fd + psfe_pkg::RND_S;
    if (node_cnt == psfe_pkg::NODE_APEX) begin
      v_val  = zs;
      v_xi   = '0;
      v_eta  = '0;
      v_zeta = psfe_pkg::ONE_S;
    end else begin
      v_val  = t_val >>> 2;
      v_xi   = (sx_pos ? psfe_pkg::QTR_S : -psfe_pkg::QTR_S) + (t_b >>> 2);
      v_eta  = (sy_pos ? psfe_pkg::QTR_S : -psfe_pkg::QTR_S) + (t_c >>> 2);
      v_zeta = hc.apex ? -psfe_pkg::QTR_S : -psfe_pkg::QTR_S + (t_d >>> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_ptr <= '0;
      fill_ptr  <= '0;
      rd_ptr    <= '0;
      n_alloc   <= '0;
      n_ready   <= '0;
      node_cnt  <= psfe_pkg::NODE_FIRST;
      ovalid    <= 1'b0;
    end else begin
      if (alloc) alloc_ptr <= alloc_ptr + 1'b1;
      if (fill_done) fill_ptr <= fill_ptr + 1'b1;
      if (free) rd_ptr <= rd_ptr + 1'b1;
      n_alloc <= n_alloc + psfe_pkg::CNT_W'(alloc) - psfe_pkg::CNT_W'(free);
      n_ready <= n_ready + psfe_pkg::CNT_W'(fill_done) - psfe_pkg::CNT_W'(free);
      if (ld) begin
        ovalid   <= 1'b1;
        node_cnt <= free ? psfe_pkg::NODE_FIRST : node_cnt + 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) ctx_mem[alloc_ptr] <= ctx;
    if (res.valid) begin
      fpos_mem[fill_ptr][res.op] <= f_pos;
      fneg_mem[fill_ptr][res.op] <= f_neg;
    end
    if (ld) begin
      node        <= node_cnt;
      shape_value <= psfe_pkg::sat_out(v_val);
      deriv_xi    <= psfe_pkg::sat_out(v_xi);
      deriv_eta   <= psfe_pkg::sat_out(v_eta);
      deriv_zeta  <= psfe_pkg::sat_out(v_zeta);
      outside     <= hc.outside;
      last        <= (node_cnt == psfe_pkg::NODE_APEX);
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_le_alloc: assert property (@(posedge clk) disable iff (rst)
    n_ready <= n_alloc) else $error("more filled entries than allocated");

  a_res_has_slot: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (n_ready < n_alloc)) else $error("divider result without a slot");

  a_apex_follows: assert property (@(posedge clk) disable iff (rst)
    (pop && ovalid && node == psfe_pkg::NODE_LAST_BASE) |=>
      (ovalid && node == psfe_pkg::NODE_APEX)) else $error("apex beat did not follow");
`endif

endmodule

/* rtl/core/pyramid_shape_function_eval_core.sv */
// Top level of the linear pyramid element shape function evaluator.
//
//   channel | handshake          | beat
//   input   | push / full        | xi, eta, zeta (one local point)
//   result  | pop / empty        | node, shape_value, deriv_xi, deriv_eta, deriv_zeta,
//           |                    | outside, last (five beats per point, apex last)
//
// Each point issues four ops into a pipelined divider (one quotient bit per stage),
// then yields five result beats, so the result port sets the sustained rate.
// Up to QDEPTH points are in flight; full rises when that queue is reserved and
// also while the front end has not yet reached the last op of the accepted point.
// rst is synchronous and clears all control state; results stall freely on pop.
`timescale 1ns / 1ps
module pyramid_shape_function_eval_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [psfe_pkg::IN_W-1:0]    xi,
  input  logic signed [psfe_pkg::IN_W-1:0]    eta,
  input  logic signed [psfe_pkg::IN_W-1:0]    zeta,
  output logic                                empty,
  input  logic                                pop,
  output logic [psfe_pkg::NODE_W-1:0]         node,
  output logic signed [psfe_pkg::OUT_W-1:0]   shape_value,
  output logic signed [psfe_pkg::OUT_W-1:0]   deriv_xi,
  output logic signed [psfe_pkg::OUT_W-1:0]   deriv_eta,
  output logic signed [psfe_pkg::OUT_W-1:0]   deriv_zeta,
  output logic                                outside,
  output logic                                last
);

  logic               q_full;
  logic               alloc;
  psfe_pkg::ctx_t     ctx;
  psfe_pkg::div_req_t req;
  psfe_pkg::div_res_t res;

  psfe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .xi     (xi),
    .eta    (eta),
    .zeta   (zeta),
    .q_full (q_full),
    .alloc  (alloc),
    .ctx    (ctx),
    .req    (req)
  );

  psfe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  psfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .alloc       (alloc),
    .ctx         (ctx),
    .q_full      (q_full),
    .res         (res),
    .empty       (empty),
    .pop         (pop),
    .node        (node),
    .shape_value (shape_value),
    .deriv_xi    (deriv_xi),
    .deriv_eta   (deriv_eta),
    .deriv_zeta  (deriv_zeta),
    .outside     (outside),
    .last        (last)
  );

endmodule

/* bench/tb_pyramid_shape_function_eval_core.sv */
// Testbench for the pyramid shape function evaluator: directed and random points.
`timescale 1ns / 1ps
module tb_pyramid_shape_function_eval_core;

  typedef struct packed {
    logic [psfe_pkg::NODE_W-1:0]       node;
    logic signed [psfe_pkg::OUT_W-1:0] val;
    logic signed [psfe_pkg::OUT_W-1:0] dxi;
    logic signed [psfe_pkg::OUT_W-1:0] deta;
    logic signed [psfe_pkg::OUT_W-1:0] dzeta;
    logic                              outside;
    logic                              last;
  } node_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [psfe_pkg::IN_W-1:0] xi = '0, eta = '0, zeta = '0;
  logic [psfe_pkg::NODE_W-1:0] node;
  logic signed [psfe_pkg::OUT_W-1:0] shape_value, deriv_xi, deriv_eta, deriv_zeta;
  logic outside, last;

  node_beat_t node_q[$];
  int errors = 0;
  int hold_pop = 0;
  bit rx_free = 1'b0;

  pyramid_shape_function_eval_core dut (.*);

  initial forever #4 clk = ~clk;

  initial begin
    #4000000;
    $display("tb_pyramid_shape_function_eval_core: done, errors");
    $finish;
  end

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint rq(longint n, longint d);
    longint q, q4;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = fdiv(n, d);
    q4 = fdiv(q, 4);
    return q4 + ((q - 4 * q4) >= 2 ? 1 : 0);
  endfunction

  function automatic logic signed [psfe_pkg::OUT_W-1:0] clip(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[psfe_pkg::OUT_W-1:0];
  endfunction

  // Expected node beats for one point
  task automatic predict_nodes(longint x, longint y, longint z);
    longint s, qs, d, den, sx, sy, sxy;
    bit apex;
    node_beat_t b;
    s = longint'(1) << psfe_pkg::FRAC_BITS;
    qs = s / 4;
    apex = (z == s);
    d = s - z;
    den = apex ? s : d;
    for (int k = 0; k < 4; k++) begin
      sx = (k == 0 || k == 3) ? 1 : -1;
      sy = (k < 2) ? 1 : -1;
      sxy = sx * sy;
      b.node = k[psfe_pkg::NODE_W-1:0];
      b.val = clip(rq((s + sx * x + sy * y - z) * den + sxy * x * y, den));
      b.dxi = clip(sx * qs + rq(sxy * y * s, den));
      b.deta = clip(sy * qs + rq(sxy * x * s, den));
      b.dzeta = clip(apex ? -qs : -qs + rq(sxy * x * y * s, d * d));
      b.outside = (z < 0);
      b.last = 1'b0;
      node_q.push_back(b);
    end
    b.node = psfe_pkg::NODE_APEX;
    b.val = clip(z);
    b.dxi = '0;
    b.deta = '0;
    b.dzeta = clip(s);
    b.outside = (z < 0);
    b.last = 1'b1;
    node_q.push_back(b);
  endtask

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  // Receiver: random pop gaps, steady pop if rx_free, long hold while hold_pop > 0
  always @(posedge clk) begin
    node_beat_t e;
    if (!rst && pop && !empty) begin
      if (node_q.size() == 0) report("unexpected beat node", node, -1);
      else begin
        e = node_q.pop_front();
        if (node !== e.node) report("node", node, e.node);
        if (shape_value !== e.val) report("shape_value", shape_value, e.val);
        if (deriv_xi !== e.dxi) report("deriv_xi", deriv_xi, e.dxi);
        if (deriv_eta !== e.deta) report("deriv_eta", deriv_eta, e.deta);
        if (deriv_zeta !== e.dzeta) report("deriv_zeta", deriv_zeta, e.dzeta);
        if (outside !== e.outside) report("outside", outside, e.outside);
        if (last !== e.last) report("last", last, e.last);
      end
    end
    if (hold_pop > 0) begin
      hold_pop <= hold_pop - 1;
      pop <= 1'b0;
    end else if (rx_free) pop <= 1'b1;
    else pop <= ($urandom_range(0, 9) < 7) ||
                ($urandom_range(0, 30) == 0 ? 1'b0 : $urandom_range(0, 1));
  end

  // Drop push only when the gap really spans clock edges
  task automatic gap();
    int n;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_point(logic signed [psfe_pkg::IN_W-1:0] x,
                            logic signed [psfe_pkg::IN_W-1:0] y,
                            logic signed [psfe_pkg::IN_W-1:0] z, bit no_gap);
    push <= 1'b1;
    xi <= x;
    eta <= y;
    zeta <= z;
    do @(posedge clk); while (full);
    predict_nodes(x, y, z);
    if (!no_gap && $urandom_range(0, 2) == 0) gap();
  endtask

  task automatic idle_sender();
    push <= 1'b0;
  endtask

  function automatic logic signed [psfe_pkg::IN_W-1:0] rcoord();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return '0;
      3: return psfe_pkg::IN_W'($urandom);  // any bit pattern
      default: return psfe_pkg::IN_W'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [psfe_pkg::IN_W-1:0] v[5] =
      '{-16'sd16384, -16'sd1, 16'sd0, 16'sd8192, 16'sd16384};
    foreach (v[i]) send_point(v[i], v[4 - i], v[i], 1'b0);
    send_point(16'sd16384, 16'sd16384, 16'sd16383, 1'b0);  // near apex, large terms
    send_point(-16'sd16384, 16'sd16384, 16'sd16383, 1'b0);
    send_point(16'sd5, -16'sd7, 16'sd16384, 1'b0);          // apex exact
    send_point(16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);     // raw extremes
    send_point(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0);     // zeta above one
    send_point(16'sd3, 16'sd3, -16'sd1, 1'b0);              // just outside
    send_point(16'sh5555, 16'shaaaa, 16'sh2aaa, 1'b0);
    send_point(16'shaaaa, 16'sh5555, 16'shd555, 1'b0);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (node_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic test_backpressure();
    hold_pop = 200;
    for (int i = 0; i < 30; i++) send_point(rcoord(), rcoord(), rcoord(), 1'b1);
    idle_sender();
    drain();  // sender pauses until all beats are back
  endtask

  task automatic test_random();
    for (int i = 0; i < 150; i++) begin
      if (i == 75) rx_free = 1'b1;
      if (i == 110) rx_free = 1'b0;
      send_point(rcoord(), rcoord(), rcoord(), i >= 75 && i < 110);
    end
    idle_sender();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && node_q.size() == 0)
      $display("tb_pyramid_shape_function_eval_core: done, clean");
    else
      $display("tb_pyramid_shape_function_eval_core: done, errors");
    $finish;
  end
endmodule
